FILE: hdl/nbg_pkg.sv
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared types, constants and saturation helpers for the gravity step block.
// ----------------------------------------------------------------------------
`default_nettype none

package nbg_pkg;

  localparam int MAX_PARTICLES = 64;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int N_W           = IDX_W + 1;
  localparam int FRAC_BITS     = 32;
  localparam int FRIC_BITS     = 32;
  localparam int VAL_W         = 48;
  localparam int VEC_W         = 3 * VAL_W;
  localparam int AC_W          = 7;
  localparam int CFG_AW        = 6;
  localparam int MUL_W         = 64;
  localparam int DIV_W         = 128;
  localparam int SUM_W         = 56;
  localparam int S_W           = 98;
  localparam int SQ_W          = 100;
  localparam int SQ_STEPS      = 50;
  localparam int D_W           = 50;
  localparam int F_SHIFT       = 48;

  localparam logic [2:0] REG_GRAVITY  = 3'd0;
  localparam logic [2:0] REG_SOFTEN   = 3'd1;
  localparam logic [2:0] REG_STEP     = 3'd2;
  localparam logic [2:0] REG_FRICTION = 3'd3;
  localparam logic [2:0] REG_ACTIVE   = 3'd4;

  typedef logic signed [VAL_W-1:0] val_t;

  typedef struct packed {
    logic       operation;
    logic [5:0] particle_index;
    val_t       load_pos_x;
    val_t       load_pos_y;
    val_t       load_pos_z;
    val_t       load_vel_x;
    val_t       load_vel_y;
    val_t       load_vel_z;
  } in_item_t;

  typedef struct packed {
    logic [5:0] out_index;
    val_t       new_pos_x;
    val_t       new_pos_y;
    val_t       new_pos_z;
    val_t       new_vel_x;
    val_t       new_vel_y;
    val_t       new_vel_z;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [47:0] gravity_strength;
    logic [31:0] softening_term;
    logic [31:0] step_time;
    logic [31:0] friction;
  } cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_I,
    OP_RD_J,
    OP_CAP_I,
    OP_CLR_SUM,
    OP_DIFF,
    OP_MUL_SQ,
    OP_ADD_S,
    OP_SQRT_GO,
    OP_DEN,
    OP_DIV_F,
    OP_F,
    OP_DIV_U,
    OP_U,
    OP_MUL_FU,
    OP_C,
    OP_WR_ACC,
    OP_MUL_DT2,
    OP_DT2,
    OP_CAP_V,
    OP_MUL_ADT,
    OP_V1,
    OP_MUL_VFR,
    OP_V2,
    OP_MUL_VDT,
    OP_T2,
    OP_MUL_ADT2,
    OP_P,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_A_CLR,
    ST_A_RDI,
    ST_A_CAPI,
    ST_A_JCHK,
    ST_A_DIFF,
    ST_A_SQ,
    ST_A_SQW,
    ST_A_SQRT,
    ST_A_SQRTW,
    ST_A_FGO,
    ST_A_FW,
    ST_A_UGO,
    ST_A_UW,
    ST_A_CGO,
    ST_A_CW,
    ST_A_WRACC,
    ST_B_DT2,
    ST_B_DT2W,
    ST_B_RD,
    ST_B_CAP,
    ST_B_M1,
    ST_B_M1W,
    ST_B_M2,
    ST_B_M2W,
    ST_B_M3,
    ST_B_M3W,
    ST_B_M4,
    ST_B_M4W,
    ST_B_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [1:0]       k;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic s_zero;
    logic den_zero;
  } stat_t;

  function automatic logic [63:0] sat64(input logic [DIV_W-1:0] v);
    return (v[DIV_W-1:64] != '0) ? '1 : v[63:0];
  endfunction

  // sign-magnitude to signed 48, saturating
  function automatic val_t sat_sgn(input logic neg, input logic [63:0] m);
    logic [VAL_W-1:0] t;
    t = ~m[VAL_W-1:0] + VAL_W'(1);
    if (neg) begin
      return (m > (64'd1 << (VAL_W - 1))) ? val_t'({1'b1, {(VAL_W-1){1'b0}}}) : val_t'(t);
    end
    return (m > {{(64-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}}) ?
           val_t'({1'b0, {(VAL_W-1){1'b1}}}) : val_t'(m[VAL_W-1:0]);
  endfunction

  function automatic val_t sat48(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(VAL_W-1){1'b1}}});
    lo = -(SUM_W'(1) <<< (VAL_W - 1));
    if (v > hi) return val_t'(hi);
    if (v < lo) return val_t'(lo);
    return val_t'(v);
  endfunction

  function automatic logic [63:0] mag48(input val_t v);
    logic [VAL_W-1:0] u;
    logic [VAL_W-1:0] m;
    u = v;
    m = u[VAL_W-1] ? (~u + VAL_W'(1)) : u;
    return {{(64-VAL_W){1'b0}}, m};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx(input val_t v);
    return SUM_W'(v);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/nbg_mul.sv
// ----------------------------------------------------------------------------
// nbg_mul
// Shift-add multiplier, 64 x 64 to 128 bits, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nbg_mul import nbg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [MUL_W-1:0]    a,
  input  wire logic [MUL_W-1:0]    b,
  output logic [2*MUL_W-1:0]       prod,
  output logic                     busy,
  output logic                     done
);

  localparam int CNT_W = $clog2(MUL_W);

  logic [2*MUL_W-1:0] prod_r;
  logic [MUL_W-1:0]   mc_r;
  logic [MUL_W-1:0]   mpl_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [MUL_W:0]     sum;
  logic               fin;

  assign sum = {1'b0, prod_r[2*MUL_W-1:MUL_W]} + (mpl_r[0] ? {1'b0, mc_r} : '0);
  assign fin = busy_r && (cnt_r == CNT_W'(MUL_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (fin) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r <= '0;
      mc_r   <= b;
      mpl_r  <= a;
    end else if (busy_r) begin
      prod_r <= {sum, prod_r[MUL_W-1:1]};
      mpl_r  <= mpl_r >> 1;
    end
  end

  assign prod = prod_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: hdl/nbg_div.sv
// ----------------------------------------------------------------------------
// nbg_div
// Restoring divider, 128 / 64 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module nbg_div import nbg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  dividend,
  input  wire logic [63:0]       divisor,
  output logic [DIV_W-1:0]       quot,
  output logic                   busy,
  output logic                   done
);

  localparam int CNT_W = $clog2(DIV_W);

  logic [DIV_W-1:0] dvd_r;
  logic [DIV_W-1:0] q_r;
  logic [63:0]      rem_r;
  logic [63:0]      dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [64:0]      rem_sh;
  logic [64:0]      rem_sub;
  logic             ge;
  logic             fin;

  assign rem_sh  = {rem_r, dvd_r[DIV_W-1]};
  assign ge      = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};
  assign fin     = busy_r && (cnt_r == CNT_W'(DIV_W - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= fin;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (fin) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= ge ? rem_sub[63:0] : rem_sh[63:0];
      q_r   <= {q_r[DIV_W-2:0], ge};
    end
  end

  assign quot = q_r;
  assign busy = busy_r;
  assign done = done_r;

endmodule

`default_nettype wire

FILE: hdl/nbg_dp.sv
// ----------------------------------------------------------------------------
// nbg_dp
// Datapath: particle stores, pair force terms, square root, integration.
// ----------------------------------------------------------------------------
`default_nettype none

module nbg_dp import nbg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cmd_t      cmd,
  input  wire cfg_t      cfg,
  input  wire in_item_t  in_item,
  output stat_t          stat,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int SQ_CW = $clog2(SQ_STEPS);

  logic [VEC_W-1:0] pos_mem [MAX_PARTICLES];
  logic [VEC_W-1:0] vel_mem [MAX_PARTICLES];
  logic [VEC_W-1:0] acc_mem [MAX_PARTICLES];
  logic [VEC_W-1:0] rd_pos_r, rd_vel_r, rd_acc_r;

  val_t                    pi_r [3];
  logic [VAL_W-1:0]        mag_r [3];
  logic                    neg_r [3];
  logic signed [SUM_W-1:0] sum_r [3];
  val_t                    av_r [3];
  val_t                    vv_r [3];
  val_t                    pv_r [3];
  logic signed [SUM_W-1:0] pacc_r;
  logic [S_W-1:0]          s_r;
  logic [D_W-1:0]          d_r;
  logic [63:0]             den_r, f_r, u_r, dt2_r;
  logic                    mneg_r;

  logic [SQ_W-1:0]  sq_op_r, sq_res_r, sq_one_r, sq_sum;
  logic [SQ_CW-1:0] sq_cnt_r;
  logic             sq_busy_r, sq_done_r, sq_fin, sq_ge;

  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic               load_ok;
  logic               mul_go, mul_neg, mul_busy, mul_done;
  logic [MUL_W-1:0]   mul_a, mul_b;
  logic [2*MUL_W-1:0] prod;
  logic               div_go, div_busy, div_done;
  logic [DIV_W-1:0]   div_n, quot;
  logic [63:0]        div_d;
  logic [63:0]        d2;
  logic [64:0]        den_sum;
  val_t               smul_f, smul_f1, smul_32;
  logic               out_valid_r;
  out_item_t          out_item_r;

  assign load_ok = int'(in_item.particle_index) < MAX_PARTICLES;
  assign rd_addr = (cmd.op == OP_RD_J) ? cmd.j : cmd.i;
  assign wr_addr = (cmd.op == OP_LOAD) ? IDX_W'(in_item.particle_index) : cmd.i;

  always_ff @(posedge clk) begin
    if ((cmd.op == OP_LOAD && load_ok) || cmd.op == OP_EMIT) begin
      pos_mem[wr_addr] <= (cmd.op == OP_LOAD) ?
        {in_item.load_pos_z, in_item.load_pos_y, in_item.load_pos_x} :
        {pv_r[2], pv_r[1], pv_r[0]};
      vel_mem[wr_addr] <= (cmd.op == OP_LOAD) ?
        {in_item.load_vel_z, in_item.load_vel_y, in_item.load_vel_x} :
        {vv_r[2], vv_r[1], vv_r[0]};
    end
    if (cmd.op == OP_WR_ACC) begin
      acc_mem[cmd.i] <= {sat48(sum_r[2]), sat48(sum_r[1]), sat48(sum_r[0])};
    end
    rd_pos_r <= pos_mem[rd_addr];
    rd_vel_r <= vel_mem[rd_addr];
    rd_acc_r <= acc_mem[rd_addr];
  end

  // multiplier and divider operand select
  always_comb begin
    mul_go  = 1'b0;
    mul_neg = 1'b0;
    mul_a   = '0;
    mul_b   = '0;
    div_go  = 1'b0;
    div_n   = '0;
    div_d   = '0;
    case (cmd.op)
      OP_MUL_SQ: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(mag_r[cmd.k]);
        mul_b  = MUL_W'(mag_r[cmd.k]);
      end
      OP_MUL_FU: begin
        mul_go = 1'b1;
        mul_a  = f_r;
        mul_b  = u_r;
      end
      OP_MUL_DT2: begin
        mul_go = 1'b1;
        mul_a  = MUL_W'(cfg.step_time);
        mul_b  = MUL_W'(cfg.step_time);
      end
      OP_MUL_ADT: begin
        mul_go  = 1'b1;
        mul_neg = av_r[cmd.k][VAL_W-1];
        mul_a   = mag48(av_r[cmd.k]);
        mul_b   = MUL_W'(cfg.step_time);
      end
      OP_MUL_VFR: begin
        mul_go  = 1'b1;
        mul_neg = vv_r[cmd.k][VAL_W-1];
        mul_a   = mag48(vv_r[cmd.k]);
        mul_b   = MUL_W'(cfg.friction);
      end
      OP_MUL_VDT: begin
        mul_go  = 1'b1;
        mul_neg = vv_r[cmd.k][VAL_W-1];
        mul_a   = mag48(vv_r[cmd.k]);
        mul_b   = MUL_W'(cfg.step_time);
      end
      OP_MUL_ADT2: begin
        mul_go  = 1'b1;
        mul_neg = av_r[cmd.k][VAL_W-1];
        mul_a   = mag48(av_r[cmd.k]);
        mul_b   = dt2_r;
      end
      OP_DIV_F: begin
        div_go = 1'b1;
        div_n  = DIV_W'(cfg.gravity_strength) << (2 * FRAC_BITS);
        div_d  = den_r;
      end
      OP_DIV_U: begin
        div_go = 1'b1;
        div_n  = DIV_W'(mag_r[cmd.k]) << FRAC_BITS;
        div_d  = 64'(d_r);
      end
      default: ;
    endcase
  end

  nbg_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .busy  (mul_busy),
    .done  (mul_done)
  );

  nbg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_n),
    .divisor  (div_d),
    .quot     (quot),
    .busy     (div_busy),
    .done     (div_done)
  );

  // digit-by-digit square root, one result bit per cycle
  assign sq_sum = sq_res_r + sq_one_r;
  assign sq_ge  = sq_op_r >= sq_sum;
  assign sq_fin = sq_busy_r && (sq_cnt_r == SQ_CW'(SQ_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
      sq_done_r <= 1'b0;
      sq_cnt_r  <= '0;
    end else begin
      sq_done_r <= sq_fin;
      if (cmd.op == OP_SQRT_GO) begin
        sq_busy_r <= 1'b1;
        sq_cnt_r  <= '0;
      end else if (sq_busy_r) begin
        sq_cnt_r <= sq_cnt_r + SQ_CW'(1);
        if (sq_fin) sq_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SQRT_GO) begin
      sq_op_r  <= SQ_W'(s_r);
      sq_res_r <= '0;
      sq_one_r <= SQ_W'(1) << (2 * (SQ_STEPS - 1));
    end else if (sq_busy_r) begin
      sq_op_r  <= sq_ge ? (sq_op_r - sq_sum) : sq_op_r;
      sq_res_r <= sq_ge ? ((sq_res_r >> 1) + sq_one_r) : (sq_res_r >> 1);
      sq_one_r <= sq_one_r >> 2;
    end
  end

  assign d2      = sat64(DIV_W'(s_r) >> FRAC_BITS);
  assign den_sum = {1'b0, d2} + 65'(cfg.softening_term);
  assign smul_f  = sat_sgn(mneg_r, sat64(prod >> FRAC_BITS));
  assign smul_f1 = sat_sgn(mneg_r, sat64(prod >> (FRAC_BITS + 1)));
  assign smul_32 = sat_sgn(mneg_r, sat64(prod >> FRIC_BITS));

  always_ff @(posedge clk) begin
    if (mul_go) mneg_r <= mul_neg;
    case (cmd.op)
      OP_CAP_I: begin
        for (int k = 0; k < 3; k++) pi_r[k] <= val_t'(rd_pos_r[k*VAL_W +: VAL_W]);
      end
      OP_CLR_SUM: begin
        for (int k = 0; k < 3; k++) sum_r[k] <= '0;
      end
      OP_DIFF: begin
        for (int k = 0; k < 3; k++) begin
          logic signed [VAL_W:0] df;
          df = (VAL_W+1)'(val_t'(rd_pos_r[k*VAL_W +: VAL_W])) - (VAL_W+1)'(pi_r[k]);
          neg_r[k] <= df[VAL_W];
          mag_r[k] <= df[VAL_W] ? VAL_W'(-df) : VAL_W'(df);
        end
        s_r <= '0;
      end
      OP_ADD_S:  s_r   <= s_r + prod[S_W-1:0];
      OP_DEN: begin
        d_r   <= sq_res_r[D_W-1:0];
        den_r <= den_sum[64] ? '1 : den_sum[63:0];
      end
      OP_F:      f_r   <= sat64(quot >> F_SHIFT);
      OP_U:      u_r   <= sat64(quot);
      OP_C:      sum_r[cmd.k] <= sum_r[cmd.k] +
                                 sx(sat_sgn(neg_r[cmd.k], sat64(prod >> FRAC_BITS)));
      OP_DT2:    dt2_r <= sat64(prod >> FRAC_BITS);
      OP_CAP_V: begin
        for (int k = 0; k < 3; k++) begin
          av_r[k] <= val_t'(rd_acc_r[k*VAL_W +: VAL_W]);
          vv_r[k] <= val_t'(rd_vel_r[k*VAL_W +: VAL_W]);
          pv_r[k] <= val_t'(rd_pos_r[k*VAL_W +: VAL_W]);
        end
      end
      OP_V1:     vv_r[cmd.k] <= sat48(sx(vv_r[cmd.k]) + sx(smul_f));
      OP_V2:     vv_r[cmd.k] <= smul_32;
      OP_T2:     pacc_r      <= sx(pv_r[cmd.k]) + sx(smul_f);
      OP_P:      pv_r[cmd.k] <= sat48(pacc_r + sx(smul_f1));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_item_r.out_index <= 6'(cmd.i);
      out_item_r.new_pos_x <= pv_r[0];
      out_item_r.new_pos_y <= pv_r[1];
      out_item_r.new_pos_z <= pv_r[2];
      out_item_r.new_vel_x <= vv_r[0];
      out_item_r.new_vel_y <= vv_r[1];
      out_item_r.new_vel_z <= vv_r[2];
      out_item_r.last      <= cmd.last;
    end
  end

  assign stat.done     = mul_done | div_done | sq_done_r;
  assign stat.s_zero   = (s_r == '0);
  assign stat.den_zero = (den_r == '0);
  assign out_valid     = out_valid_r;
  assign out_item      = out_item_r;

  // only one arithmetic unit runs at a time
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({mul_busy, div_busy, sq_busy_r}))
    else $error("more than one arithmetic unit busy");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.last) |=> !out_valid_r)
    else $error("item emitted right after the last one");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    stat.done |=> !stat.done)
    else $error("unit completion held longer than one cycle");

endmodule

`default_nettype wire

FILE: hdl/nbg_ctrl.sv
// ----------------------------------------------------------------------------
// nbg_ctrl
// Sequencer: issues loads; walks particle pairs for the forces, then integrates each one.
// ----------------------------------------------------------------------------
`default_nettype none

module nbg_ctrl import nbg_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic           in_op,
  input  wire logic [N_W-1:0] n,
  input  wire stat_t          stat,
  output cmd_t                cmd,
  output logic                busy
);

  ctrl_state_t      state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [N_W-1:0]   j_r, j_nxt;
  logic [1:0]       k_r, k_nxt;
  dp_op_t           op;
  logic             i_last;

  assign i_last = (N_W'(i_r) == (n - N_W'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    op        = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (!in_op) begin
            op = OP_LOAD;
          end else if (n != '0) begin
            i_nxt     = '0;
            state_nxt = ST_A_CLR;
          end
        end
      end
      ST_A_CLR: begin
        op        = OP_CLR_SUM;
        j_nxt     = '0;
        state_nxt = ST_A_RDI;
      end
      ST_A_RDI: begin
        op        = OP_RD_I;
        state_nxt = ST_A_CAPI;
      end
      ST_A_CAPI: begin
        op        = OP_CAP_I;
        state_nxt = ST_A_JCHK;
      end
      ST_A_JCHK: begin
        if (j_r == n) begin
          state_nxt = ST_A_WRACC;
        end else if (j_r == N_W'(i_r)) begin
          j_nxt = j_r + N_W'(1);
        end else begin
          op        = OP_RD_J;
          state_nxt = ST_A_DIFF;
        end
      end
      ST_A_DIFF: begin
        op        = OP_DIFF;
        k_nxt     = '0;
        state_nxt = ST_A_SQ;
      end
      ST_A_SQ: begin
        op        = OP_MUL_SQ;
        state_nxt = ST_A_SQW;
      end
      ST_A_SQW: begin
        if (stat.done) begin
          op = OP_ADD_S;
          if (k_r == 2'd2) begin
            state_nxt = ST_A_SQRT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_A_SQ;
          end
        end
      end
      ST_A_SQRT: begin
        if (stat.s_zero) begin
          j_nxt     = j_r + N_W'(1);
          state_nxt = ST_A_JCHK;
        end else begin
          op        = OP_SQRT_GO;
          state_nxt = ST_A_SQRTW;
        end
      end
      ST_A_SQRTW: begin
        if (stat.done) begin
          op        = OP_DEN;
          state_nxt = ST_A_FGO;
        end
      end
      ST_A_FGO: begin
        if (stat.den_zero) begin
          j_nxt     = j_r + N_W'(1);
          state_nxt = ST_A_JCHK;
        end else begin
          op        = OP_DIV_F;
          state_nxt = ST_A_FW;
        end
      end
      ST_A_FW: begin
        if (stat.done) begin
          op        = OP_F;
          k_nxt     = '0;
          state_nxt = ST_A_UGO;
        end
      end
      ST_A_UGO: begin
        op        = OP_DIV_U;
        state_nxt = ST_A_UW;
      end
      ST_A_UW: begin
        if (stat.done) begin
          op        = OP_U;
          state_nxt = ST_A_CGO;
        end
      end
      ST_A_CGO: begin
        op        = OP_MUL_FU;
        state_nxt = ST_A_CW;
      end
      ST_A_CW: begin
        if (stat.done) begin
          op = OP_C;
          if (k_r == 2'd2) begin
            j_nxt     = j_r + N_W'(1);
            state_nxt = ST_A_JCHK;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_A_UGO;
          end
        end
      end
      ST_A_WRACC: begin
        op = OP_WR_ACC;
        if (i_last) begin
          state_nxt = ST_B_DT2;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_A_CLR;
        end
      end
      ST_B_DT2: begin
        op        = OP_MUL_DT2;
        state_nxt = ST_B_DT2W;
      end
      ST_B_DT2W: begin
        if (stat.done) begin
          op        = OP_DT2;
          i_nxt     = '0;
          state_nxt = ST_B_RD;
        end
      end
      ST_B_RD: begin
        op        = OP_RD_I;
        state_nxt = ST_B_CAP;
      end
      ST_B_CAP: begin
        op        = OP_CAP_V;
        k_nxt     = '0;
        state_nxt = ST_B_M1;
      end
      ST_B_M1: begin
        op        = OP_MUL_ADT;
        state_nxt = ST_B_M1W;
      end
      ST_B_M1W: begin
        if (stat.done) begin
          op        = OP_V1;
          state_nxt = ST_B_M2;
        end
      end
      ST_B_M2: begin
        op        = OP_MUL_VFR;
        state_nxt = ST_B_M2W;
      end
      ST_B_M2W: begin
        if (stat.done) begin
          op        = OP_V2;
          state_nxt = ST_B_M3;
        end
      end
      ST_B_M3: begin
        op        = OP_MUL_VDT;
        state_nxt = ST_B_M3W;
      end
      ST_B_M3W: begin
        if (stat.done) begin
          op        = OP_T2;
          state_nxt = ST_B_M4;
        end
      end
      ST_B_M4: begin
        op        = OP_MUL_ADT2;
        state_nxt = ST_B_M4W;
      end
      ST_B_M4W: begin
        if (stat.done) begin
          op = OP_P;
          if (k_r == 2'd2) begin
            state_nxt = ST_B_EMIT;
          end else begin
            k_nxt     = k_r + 2'd1;
            state_nxt = ST_B_M1;
          end
        end
      end
      ST_B_EMIT: begin
        op = OP_EMIT;
        if (i_last) begin
          state_nxt = ST_IDLE;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_B_RD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign cmd.op   = op;
  assign cmd.i    = i_r;
  assign cmd.j    = j_r[IDX_W-1:0];
  assign cmd.k    = k_r;
  assign cmd.last = i_last;
  assign busy     = (state_r != ST_IDLE);

endmodule

`default_nettype wire

FILE: hdl/nbody_gravity_step.sv
// ----------------------------------------------------------------------------
// nbody_gravity_step
// All-pairs gravity integrator for up to 64 particles in signed Q16.32.
//
//   channel  ports                                    transfer
//   in       start, busy, in_item                     start && !busy
//   out      out_valid, out_item                      out_valid, one cycle
//   cfg      psel penable pwrite paddr pwdata prdata  APB, pready tied high
//
// A load leaves busy low. In a step over n particles, each pair runs three
// squaring multiplies and, unless its distance or denominator is zero, a
// root, four divides and three more multiplies on the shared serial units,
// and each particle update runs twelve multiplies.
// Reset clears control state and sets config defaults; the particle stores are
// undefined until loaded. Results are strobed once and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module nbody_gravity_step import nbg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire in_item_t          in_item,
  output logic                   out_valid,
  output out_item_t              out_item,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready
);

  logic [47:0]     gs_r;
  logic [31:0]     soft_r;
  logic [31:0]     dt_r;
  logic [31:0]     fr_r;
  logic [AC_W-1:0] ac_r;
  logic [2:0]      reg_idx;
  logic            wr_en;
  logic [N_W-1:0]  n;
  cfg_t            cfg;
  cmd_t            cmd;
  stat_t           stat;

  assign reg_idx = paddr[CFG_AW-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gs_r   <= 48'd18786;
      soft_r <= 32'd4294967;
      dt_r   <= 32'd85899346;
      fr_r   <= 32'd4252017623;
      ac_r   <= AC_W'(64);
    end else if (wr_en) begin
      case (reg_idx)
        REG_GRAVITY:  gs_r   <= pwdata[47:0];
        REG_SOFTEN:   soft_r <= pwdata[31:0];
        REG_STEP:     dt_r   <= pwdata[31:0];
        REG_FRICTION: fr_r   <= pwdata[31:0];
        REG_ACTIVE:   ac_r   <= pwdata[AC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRAVITY:  prdata = 64'(gs_r);
      REG_SOFTEN:   prdata = 64'(soft_r);
      REG_STEP:     prdata = 64'(dt_r);
      REG_FRICTION: prdata = 64'(fr_r);
      REG_ACTIVE:   prdata = 64'(ac_r);
      default:      prdata = '0;
    endcase
  end

  assign n = (int'(ac_r) > MAX_PARTICLES) ? N_W'(MAX_PARTICLES) : N_W'(ac_r);

  assign cfg.gravity_strength = gs_r;
  assign cfg.softening_term   = soft_r;
  assign cfg.step_time        = dt_r;
  assign cfg.friction         = fr_r;

  nbg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_item.operation),
    .n     (n),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  nbg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg       (cfg),
    .in_item   (in_item),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
